### hw/rtl/hcd_pkg.sv
// Shared types and constants for the HTTP chunked body deframer.
// No dependencies; every other file of the block imports this package.
package hcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CHUNK_LEN_W = 32;
  localparam int unsigned DIGIT_W = 4;

  // Result kinds.
  localparam logic [KIND_W-1:0] K_FRAME = 3'd0;
  localparam logic [KIND_W-1:0] K_DATA  = 3'd1;
  localparam logic [KIND_W-1:0] K_DONE  = 3'd2;
  localparam logic [KIND_W-1:0] K_FINAL = 3'd3;
  localparam logic [KIND_W-1:0] K_BAD   = 3'd4;
  localparam logic [KIND_W-1:0] K_OVF   = 3'd5;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // One classified byte as it travels from the front end to the back end.
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [DIGIT_W-1:0] digit;
    logic               is_hex;
    logic               is_cr;
    logic               is_lf;
  } item_t;

endpackage

### hw/rtl/hcd_if.sv
// Valid/ready channel interfaces for the deframer: body bytes in, results out
// and the size limit register write. Depends on hcd_pkg.
interface hcd_in_if;
  import hcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface hcd_out_if;
  import hcd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [BYTE_W-1:0]      out_byte;
  logic [KIND_W-1:0]      kind;
  logic [CHUNK_LEN_W-1:0] chunk_length;
  modport source (output valid, output out_byte, output kind, output chunk_length,
                  input ready);
  modport sink (input valid, input out_byte, input kind, input chunk_length,
                output ready);
endinterface

interface hcd_cfg_if;
  import hcd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CHUNK_LEN_W-1:0] max_chunk_len;
  modport source (output valid, output max_chunk_len, input ready);
  modport sink (input valid, input max_chunk_len, output ready);
endinterface

### hw/rtl/hcd_front.sv
// Front end: takes body bytes and classifies each as hex digit, CR or LF.
// Depends on hcd_pkg and hcd_in_if.
module hcd_front (
  hcd_in_if.sink         body,
  input  logic           q_full,
  output logic           push,
  output hcd_pkg::item_t push_item
);
  import hcd_pkg::*;

  logic [BYTE_W-1:0] b;

  assign b = body.in_byte;
  assign body.ready = !q_full;
  assign push = body.valid && !q_full;

  always_comb begin
    push_item.data   = b;
    push_item.is_cr  = (b == CHAR_CR);
    push_item.is_lf  = (b == CHAR_LF);
    push_item.is_hex = 1'b1;
    push_item.digit  = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      push_item.digit = DIGIT_W'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      push_item.digit = DIGIT_W'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      push_item.digit = DIGIT_W'(b - 8'h37);
    end else begin
      push_item.is_hex = 1'b0;
    end
  end

endmodule

### hw/rtl/hcd_queue.sv
// Two-entry queue of classified bytes between the front and back ends.
// Depends on hcd_pkg.
module hcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hcd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output hcd_pkg::item_t head
);
  import hcd_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
      (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

### hw/rtl/hcd_back.sv
// Back end: framing state machine, size accumulation, limit check and the
// registered result slot. Depends on hcd_pkg, hcd_out_if and hcd_cfg_if.
module hcd_back #(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  hcd_pkg::item_t head,
  output logic           pop,
  hcd_cfg_if.sink        cfg,
  hcd_out_if.source      result
);
  import hcd_pkg::*;

  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_SIZE_LF = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_TRAIL1  = 3'd3;
  localparam logic [2:0] PH_TRAIL2  = 3'd4;
  localparam logic [2:0] PH_ERR_BAD = 3'd5;
  localparam logic [2:0] PH_ERR_OVF = 3'd6;

  logic [2:0]             phase;
  logic [2:0]             phase_next;
  logic [LEN_BITS-1:0]    size_accum;
  logic [LEN_BITS-1:0]    size_accum_next;
  logic [LEN_BITS-1:0]    bytes_left;
  logic [LEN_BITS-1:0]    bytes_left_next;
  logic [CHUNK_LEN_W-1:0] max_len;
  logic [LEN_BITS-1:0]    acc_shift;
  logic [LEN_BITS-1:0]    left_dec;
  logic [KIND_W-1:0]      kind_c;
  logic [BYTE_W-1:0]      byte_c;
  logic [LEN_BITS-1:0]    shown_c;
  logic                   out_valid;

  assign cfg.ready = 1'b1;
  assign pop = q_valid && (!out_valid || result.ready);
  assign result.valid = out_valid;

  assign acc_shift = {size_accum[LEN_BITS-5:0], head.digit};
  assign left_dec  = bytes_left - LEN_BITS'(1);

  always_comb begin
    phase_next      = phase;
    size_accum_next = size_accum;
    bytes_left_next = bytes_left;
    kind_c          = K_FRAME;
    byte_c          = '0;
    unique case (phase)
      PH_SIZE: begin
        if (head.is_cr) begin
          phase_next = PH_SIZE_LF;
        end else if (!head.is_hex) begin
          kind_c     = K_BAD;
          phase_next = PH_ERR_BAD;
        end else if (size_accum[LEN_BITS-1 -: 4] != 4'd0) begin
          kind_c     = K_OVF;
          phase_next = PH_ERR_OVF;
        end else begin
          size_accum_next = acc_shift;
          if (CHUNK_LEN_W'(acc_shift) > max_len) begin
            kind_c     = K_OVF;
            phase_next = PH_ERR_OVF;
          end
        end
      end
      PH_SIZE_LF: begin
        if (head.is_lf) begin
          bytes_left_next = size_accum;
          phase_next = (size_accum == '0) ? PH_TRAIL1 : PH_DATA;
        end else begin
          kind_c     = K_BAD;
          phase_next = PH_ERR_BAD;
        end
      end
      PH_DATA: begin
        kind_c          = K_DATA;
        byte_c          = head.data;
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_TRAIL1;
        end
      end
      PH_TRAIL1: begin
        phase_next = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        kind_c = (size_accum == '0) ? K_FINAL : K_DONE;
      end
      PH_ERR_OVF: begin
        kind_c = K_OVF;
      end
      default: begin
        kind_c     = K_BAD;
        phase_next = PH_ERR_BAD;
      end
    endcase
    shown_c = size_accum_next;
    if (kind_c == K_DONE || kind_c == K_FINAL) begin
      phase_next      = PH_SIZE;
      size_accum_next = '0;
      bytes_left_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      size_accum <= '0;
      bytes_left <= '0;
      max_len    <= '1;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_len <= cfg.max_chunk_len;
      end
      if (pop) begin
        phase      <= phase_next;
        size_accum <= size_accum_next;
        bytes_left <= bytes_left_next;
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.out_byte     <= byte_c;
      result.kind         <= kind_c;
      result.chunk_length <= CHUNK_LEN_W'(shown_c);
    end
  end

  a_bad_sticky: assert property (@(posedge clk) disable iff (rst)
      phase == PH_ERR_BAD |=> phase == PH_ERR_BAD)
    else $error("bad-digit error phase left without reset");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
      phase == PH_ERR_OVF |=> phase == PH_ERR_OVF)
    else $error("overflow error phase left without reset");
  a_data_kind: assert property (@(posedge clk) disable iff (rst)
      pop && phase == PH_DATA |=> result.kind == K_DATA)
    else $error("data phase produced a non-data result");
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && result.kind != K_DATA |-> result.out_byte == '0)
    else $error("non-data result carries a byte");
  a_data_left: assert property (@(posedge clk) disable iff (rst)
      phase == PH_DATA |-> bytes_left != '0)
    else $error("data phase with no bytes left");

endmodule

### hw/rtl/http_chunked_deframer.sv
// HTTP chunked body deframer: one result per body byte, at one byte per clock
// while results are taken. A byte accepted is written into the queue, and its
// result is registered when the back end pops it, behind any item queued ahead.
// Throughput: one byte per cycle, sustained while results are taken; the
// two-entry queue and the result register absorb a stalled output.
// Reset (rst, synchronous): size-line phase, size and count zero, limit all ones.
module http_chunked_deframer #(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  hcd_in_if.sink    body,
  hcd_cfg_if.sink   cfg,
  hcd_out_if.source result
);
  import hcd_pkg::*;

  // The front end classifies each incoming byte (hex digit value, CR, LF) and
  // pushes it into a short queue, so that the classification logic is decoupled
  // from the framing state machine; it waits only while the queue is full.
  logic  push;
  logic  q_full;
  item_t push_item;

  // The back end pops one classified byte whenever its result register is
  // free or being emptied in the same cycle, so a request is taken at every
  // clock while the consumer keeps up.
  logic  pop;
  logic  q_valid;
  item_t head;

  hcd_front u_front (
    .body      (body),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  hcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  // The framing state machine, the size accumulator with its limit check and
  // the size limit register all live in the back end. The user is to write the
  // limit only while the block is idle, so that writes need no ordering against
  // the queue contents; the block itself does not enforce this.
  hcd_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .cfg     (cfg),
    .result  (result)
  );

endmodule
